// File: hw/rtl/pis_pkg.sv
// Shared types and constants for the pair insertion sorter.
package pis_pkg;

  localparam int DATA_W            = 31;
  localparam int DEFAULT_MAX_ITEMS = 64;

  typedef logic [DATA_W-1:0] value_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    value_t value;
    logic   valid;
    logic   gt;
  } link_t;

endpackage

// File: hw/rtl/pair_insert_sorter.sv
// Top level of the pair insertion sorter: control and the chain of cells.
//
// Usage: present item_value and set_end with start high; the request is
// taken at a clock edge where start is high and busy is low. Each request
// is inserted into a chain of MAX_ITEMS cells, every cell
// comparing against the new value at once, so while loading a request can
// be taken every cycle. A request while the chain is full is dropped and
// the loss is reported on the final result of that set.
// The request that carries set_end starts output in the next cycle: busy
// goes high and the held values leave one per cycle, smallest first,
// shifted out of the first cell, each marked by valid for one cycle.
// final_flag marks the last one, with overflow on it. A set therefore
// keeps busy high until its last value has left the chain.
// The receiver takes every result; there is no back pressure.
// Reset empties the chain and clears busy, the count and the drop flag.
module pair_insert_sorter #(
  parameter int MAX_ITEMS = pis_pkg::DEFAULT_MAX_ITEMS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [pis_pkg::DATA_W-1:0] item_value,
  input  logic                      set_end,
  output logic                      valid,
  output logic [pis_pkg::DATA_W-1:0] sorted_value,
  output logic                      final_flag,
  output logic                      overflow
);
  import pis_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0]     held_count;
  logic                 dropped;
  logic                 accept;
  logic                 full;
  cell_ctrl_t           ctrl;
  link_t                links [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] valid_vec;

  assign accept      = start && !busy;
  assign full        = (held_count == CNT_W'(MAX_ITEMS));
  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = busy;

  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      link_t left_link;
      link_t right_link;
      if (i == 0) begin : g_first
        assign left_link = '{value: '0, valid: 1'b1, gt: 1'b0};
      end else begin : g_mid
        assign left_link = links[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_last
        assign right_link = '{value: '0, valid: 1'b0, gt: 1'b0};
      end else begin : g_inner
        assign right_link = links[i+1];
      end
      pis_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .item  (item_value),
        .left  (left_link),
        .right (right_link),
        .own   (links[i])
      );
      assign valid_vec[i] = links[i].valid;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      held_count <= '0;
      dropped    <= 1'b0;
    end else if (busy) begin
      held_count <= held_count - CNT_W'(1);
      if (held_count == CNT_W'(1)) begin
        busy    <= 1'b0;
        dropped <= 1'b0;
      end
    end else if (accept) begin
      if (!full) begin
        held_count <= held_count + CNT_W'(1);
      end else begin
        dropped <= 1'b1;
      end
      if (set_end) begin
        busy <= 1'b1;
      end
    end
  end

  assign valid        = busy;
  assign sorted_value = links[0].value;
  assign final_flag   = busy && (held_count == CNT_W'(1));
  assign overflow     = final_flag && dropped;

`ifndef NO_ASSERTIONS
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(held_count))
    else $error("cell occupancy differs from held count");

  a_valid_nonempty: assert property (@(posedge clk) disable iff (rst)
    valid |-> held_count != '0)
    else $error("result strobe with empty chain");

  a_final_ends_busy: assert property (@(posedge clk) disable iff (rst)
    final_flag |=> !busy && held_count == '0 && !dropped)
    else $error("block did not return to idle after final result");

  a_head_is_min: assert property (@(posedge clk) disable iff (rst)
    (busy && held_count > CNT_W'(1)) |=> links[0].value >= $past(links[0].value))
    else $error("results left out of ascending order");

  a_full_drops: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |=> dropped && held_count == CNT_W'(MAX_ITEMS))
    else $error("request on full chain not dropped");
`endif

endmodule

// File: hw/rtl/pis_cell.sv
// One cell of the sorting chain: holds a value and moves it to a neighbor.
module pis_cell (
  input  logic               clk,
  input  logic               rst,
  input  pis_pkg::cell_ctrl_t ctrl,
  input  pis_pkg::value_t    item,
  input  pis_pkg::link_t     left,
  input  pis_pkg::link_t     right,
  output pis_pkg::link_t     own
);
  import pis_pkg::*;

  value_t value;
  logic   valid;
  logic   gt;

  assign gt        = valid && (value > item);
  assign own.value = value;
  assign own.valid = valid;
  assign own.gt    = gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right.valid;
    end else if (ctrl.insert) begin
      if (left.gt || gt || (!valid && left.valid)) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right.value;
    end else if (ctrl.insert) begin
      if (left.gt) begin
        value <= left.value;
      end else if (gt || (!valid && left.valid)) begin
        value <= item;
      end
    end
  end

endmodule
